// ===== hw/rtl/time_tag_window_gate_assert.svh =====
// Assertion macros used by the checker file of the time tag window gate.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef TIME_TAG_WINDOW_GATE_ASSERT_SVH
`define TIME_TAG_WINDOW_GATE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TTWG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define TTWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ttwg_pkg.sv =====
// Types and constants of the time tag window gate.
// No dependencies; used by every module of the block but ttwg_ram.
package ttwg_pkg;

	localparam int MAX_WINDOWS = 1024;
	localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
	localparam int TIME_W      = 64;
	localparam int STATUS_W    = 3;
	localparam int REQ_W       = 2;

	// request kinds as carried in s_tuser; code 3 has no meaning and is dropped
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_TAG   = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSIDE  = 3'd0,
		ST_OUTSIDE = 3'd1,
		ST_BEFORE  = 3'd2,
		ST_LOADED  = 3'd3,
		ST_FULL    = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	// queued command: a = tag or window start, b = window end
	typedef struct packed {
		req_t              kind;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} cmd_t;

endpackage

// ===== hw/rtl/time_tag_window_gate.sv =====
// Time tag window gate, top level.
// Depends on ttwg_pkg, ttwg_front, ttwg_back (which holds ttwg_ram).
//
// Gates 64-bit time tags against a table of up to MAX_WINDOWS (1024) sorted
// windows. s_tuser picks the request: 0 appends a window (start, end), 1 gates
// a tag, 2 clears the table and rewinds the window pointer; code 3 is taken
// and dropped with no result. Every other request gives exactly one result
// transfer: m_tdata is the tag when it lies inside a window, else zero (always
// zero for loads and clears), and m_tuser is the status: 0 inside, 1 outside,
// 2 before first window or table empty, 3 loaded, 4 table full and dropped,
// 5 cleared. A tag advances a pointer that only moves forward, past every
// window whose start is no greater than the tag, and is then checked against
// the end (inclusive) of the window just before the pointer. Tags and window
// starts are expected nondecreasing; nothing checks that.
// Loads and clears are done in the back end's idle state; a tag moves on to
// the compare state and reads one window entry per pointer step there, since
// the window table is a single RAM with one registered read port. Pointer
// steps add up to at most the window count between clears. A two-entry
// command queue separates input and execution, and the result register lets
// the next tag start its pointer walk while a result still waits on m_tready.
// The table needs no clearing pass after reset: only entries below the window
// count are ever read.
module time_tag_window_gate (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // tag_time[63:0], start_time[127:64], end_time[191:128]
	input  logic [1:0]   s_tuser,   // req_type[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // gated_tag[63:0]
	output logic [2:0]   m_tuser    // status[2:0]
);
	import ttwg_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// front end: accept, classify, queue
	ttwg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back end: window table, pointer walk, result register
	ttwg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== hw/rtl/ttwg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ttwg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/ttwg_front.sv =====
// Front end: takes input transfers, drops undefined request codes and queues
// the rest in a two-entry command queue. Depends on ttwg_pkg.
module ttwg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [191:0]    s_tdata,
	input  logic [1:0]      s_tuser,
	output logic            cmd_valid,
	output ttwg_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);
	import ttwg_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       keep;
	logic       push;
	cmd_t       new_cmd;

	assign s_tready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];

	always_comb begin
		new_cmd.kind = req_t'(s_tuser);
		new_cmd.a    = s_tdata[63:0];
		new_cmd.b    = s_tdata[191:128];
		keep         = 1'b1;
		case (s_tuser)
			REQ_LOAD: begin
				new_cmd.a = s_tdata[127:64];
			end
			REQ_TAG, REQ_CLEAR: begin
				new_cmd.a = s_tdata[63:0];
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = s_tvalid && s_tready && keep;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ttwg_back.sv =====
// Back end: runs queued commands against the window table, walks the window
// pointer and holds the result register. Depends on ttwg_pkg and ttwg_ram.
module ttwg_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  ttwg_pkg::cmd_t            cmd,
	output logic                      cmd_pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [63:0]               m_tdata,
	output logic [2:0]                m_tuser
);
	import ttwg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CMP  = 2'b10
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    ptr_inc;
	logic [TIME_W-1:0]   tag_q;
	logic [TIME_W-1:0]   prev_end_q;
	logic                have_q;
	logic                out_valid_q;
	logic [TIME_W-1:0]   out_tag_q;
	status_t             out_status_q;

	logic                res_ok;
	logic                res_fire;
	logic [TIME_W-1:0]   res_tag;
	status_t             res_st;
	logic                advance;
	logic                wr_en;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [2*TIME_W-1:0] rd_data;

	// one entry holds {end, start}
	ttwg_ram #(
		.WIDTH(2 * TIME_W),
		.DEPTH(MAX_WINDOWS)
	) u_win_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data ({cmd.b, cmd.a}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_ok  = !out_valid_q || m_tready;
	assign ptr_inc = ptr_q + CNT_W'(1);
	assign advance = have_q && (tag_q >= rd_data[TIME_W-1:0]);

	always_comb begin
		cmd_pop  = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = ptr_q[IDX_W-1:0];
		res_fire = 1'b0;
		res_tag  = '0;
		res_st   = ST_INSIDE;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						REQ_LOAD: begin
							if (res_ok) begin
								cmd_pop  = 1'b1;
								res_fire = 1'b1;
								if (cnt_q == CNT_W'(MAX_WINDOWS)) begin
									res_st = ST_FULL;
								end else begin
									wr_en  = 1'b1;
									res_st = ST_LOADED;
								end
							end
						end
						REQ_CLEAR: begin
							if (res_ok) begin
								cmd_pop  = 1'b1;
								res_fire = 1'b1;
								res_st   = ST_CLEARED;
							end
						end
						REQ_TAG: begin
							cmd_pop = 1'b1;
							rd_en   = (ptr_q < cnt_q);
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			S_CMP: begin
				if (advance) begin
					rd_en   = (ptr_inc < cnt_q);
					rd_addr = ptr_inc[IDX_W-1:0];
				end else if (res_ok) begin
					res_fire = 1'b1;
					if (ptr_q == '0) begin
						res_st = ST_BEFORE;
					end else if (tag_q <= prev_end_q) begin
						res_st  = ST_INSIDE;
						res_tag = tag_q;
					end else begin
						res_st = ST_OUTSIDE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.kind == REQ_TAG) begin
			tag_q <= cmd.a;
		end
		if (state_q == S_CMP && advance) begin
			prev_end_q <= rd_data[2*TIME_W-1:TIME_W];
		end
		if (res_fire) begin
			out_tag_q    <= res_tag;
			out_status_q <= res_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.kind == REQ_TAG) begin
						have_q  <= rd_en;
						state_q <= S_CMP;
					end
					if (wr_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (cmd_pop && cmd.kind == REQ_CLEAR) begin
						cnt_q <= '0;
						ptr_q <= '0;
					end
				end
				S_CMP: begin
					if (advance) begin
						ptr_q  <= ptr_inc;
						have_q <= rd_en;
					end else if (res_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_tag_q;
	assign m_tuser  = out_status_q;

endmodule

// ===== hw/rtl/ttwg_checker.sv =====
// Port-level checker for the time tag window gate, bound to the top level.
// Depends on ttwg_pkg and time_tag_window_gate_assert.svh.
`include "time_tag_window_gate_assert.svh"

module ttwg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [191:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [2:0]   m_tuser
);
	import ttwg_pkg::*;

	// a stalled result stays offered and unchanged
	`TTWG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`TTWG_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// only an inside result may carry a nonzero tag
	`TTWG_ASSERT_NOW(a_zero_tag, m_tvalid && (m_tuser != ST_INSIDE), m_tdata == 64'd0, "nonzero tag on non-inside result")

	// status stays within the defined codes
	`TTWG_ASSERT_NOW(a_status_range, m_tvalid, (m_tuser != 3'd6) && (m_tuser != 3'd7), "undefined status code")

endmodule

bind time_tag_window_gate ttwg_checker u_ttwg_checker (.*);
